/* hw/rtl/cab_pkg.sv */
`timescale 1ns / 1ps

package cab_pkg;

   localparam int POS_W      = 13;  // pos_x / pos_y
   localparam int DIM_REG_W  = 12;  // size registers
   localparam int DIM_CALC_W = 13;  // holds any legal clamp limit
   localparam int FADE_W     = 9;
   localparam int CSR_W      = 13;  // widest register
   localparam int CSR_IDX_W  = 3;
   localparam int ADDR_W     = 22;
   localparam int PIX_W      = 32;
   localparam int CHAN_W     = 8;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_POS_X,
      CSR_POS_Y,
      CSR_IMAGE_WIDTH,
      CSR_IMAGE_HEIGHT,
      CSR_SCREEN_WIDTH,
      CSR_SCREEN_HEIGHT,
      CSR_FADE_Q8,
      CSR_ALPHA_MODE
   } csr_idx_type;

   // multiplier schedule, issued in this order
   typedef enum logic [2:0] {
      OP_ADDR,
      OP_ALPHA,
      OP_R_SRC,
      OP_R_BACK,
      OP_G_SRC,
      OP_G_BACK,
      OP_B_SRC,
      OP_B_BACK
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic write_en;
      logic blend;
      logic last;
   } job_flags_type;

   // zero reads as one, anything above lim reads as lim
   function automatic logic [DIM_CALC_W-1:0] clamp_dim(input logic [DIM_REG_W-1:0] v,
                                                        input logic [DIM_CALC_W-1:0] lim);
      logic [DIM_CALC_W-1:0] ext;
      ext = {1'b0, v};
      if (ext == '0)
         return DIM_CALC_W'(1);
      else if (ext > lim)
         return lim;
      else
         return ext;
   endfunction

endpackage

/* hw/rtl/cab_mul.sv */
`timescale 1ns / 1ps

module cab_mul #(
   parameter int W = 12
) (
   input  logic           clock,
   input  logic [W-1:0]   op_a,
   input  logic [W-1:0]   op_b,
   output logic [2*W-1:0] prod_ff
);

   logic [2*W-1:0] prod_in;

   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

/* hw/rtl/cab_pos.sv */
`timescale 1ns / 1ps

module cab_pos #(
   parameter int MAX_DIM = 2048,
   localparam int CNT_W = $clog2(MAX_DIM),
   localparam int DIM_W = $clog2(MAX_DIM + 1)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 step,
   input  logic signed [cab_pkg::POS_W-1:0]     pos_x,
   input  logic signed [cab_pkg::POS_W-1:0]     pos_y,
   input  logic [DIM_W-1:0]                     img_w,
   input  logic [DIM_W-1:0]                     img_h,
   input  logic [DIM_W-1:0]                     scr_w,
   input  logic [DIM_W-1:0]                     scr_h,
   input  logic                                 enable,
   input  logic                                 blend_mode,
   output logic [CNT_W-1:0]                     x,
   output logic [CNT_W-1:0]                     y,
   output cab_pkg::job_flags_type               flags
);

   import cab_pkg::*;

   localparam int XY_W = ((CNT_W + 1 > POS_W) ? CNT_W + 1 : POS_W) + 1;

   logic [CNT_W-1:0]       col_ff, col_in;
   logic [CNT_W-1:0]       row_ff, row_in;
   logic signed [XY_W-1:0] xs, ys;
   logic                   on_screen, end_row, end_img;

   assign xs = XY_W'(pos_x) + XY_W'($signed({1'b0, col_ff}));
   assign ys = XY_W'(pos_y) + XY_W'($signed({1'b0, row_ff}));

   assign on_screen = !xs[XY_W-1] && !ys[XY_W-1] &&
                      ($unsigned(xs) < XY_W'(scr_w)) && ($unsigned(ys) < XY_W'(scr_h));

   // counters past a shrunken size count as at the end
   assign end_row = col_ff >= CNT_W'(img_w - DIM_W'(1));
   assign end_img = end_row && (row_ff >= CNT_W'(img_h - DIM_W'(1)));

   assign x = xs[CNT_W-1:0];
   assign y = ys[CNT_W-1:0];

   assign flags.write_en = on_screen && enable;
   assign flags.blend    = blend_mode;
   assign flags.last     = end_img;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (step) begin
         if (end_row) begin
            col_in = '0;
            row_in = end_img ? '0 : row_ff + CNT_W'(1);
         end else begin
            col_in = col_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

/* hw/rtl/cab_seq.sv */
`timescale 1ns / 1ps

module cab_seq #(
   parameter int MAX_DIM = 2048,
   localparam int CNT_W = $clog2(MAX_DIM),
   localparam int DIM_W = $clog2(MAX_DIM + 1),
   localparam int MUL_W = (DIM_W > cab_pkg::FADE_W) ? DIM_W : cab_pkg::FADE_W
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [cab_pkg::PIX_W-1:0]       src,
   input  logic [cab_pkg::PIX_W-1:0]       back,
   input  cab_pkg::job_flags_type          flags,
   input  logic [CNT_W-1:0]                x,
   input  logic [CNT_W-1:0]                y,
   input  logic [DIM_W-1:0]                scr_w,
   input  logic [cab_pkg::FADE_W-1:0]      fade,
   output logic [MUL_W-1:0]                mul_a,
   output logic [MUL_W-1:0]                mul_b,
   input  logic [2*MUL_W-1:0]              mul_p,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_we,
   output logic [cab_pkg::ADDR_W-1:0]      rsp_addr,
   output logic [cab_pkg::PIX_W-1:0]       rsp_pix,
   output logic                            rsp_last
);

   import cab_pkg::*;

   localparam int PW = 2 * MUL_W;
   localparam int AW = (PW > ADDR_W) ? PW : ADDR_W;

   state_type             state_ff, state_in;
   op_type                op_ff, op_in, tag_ff, last_op;
   logic                  vld_ff, vld_in;
   logic                  start, issue, load;
   job_flags_type         flags_ff;
   logic [CNT_W-1:0]      x_ff, y_ff;
   logic [PIX_W-1:0]      src_ff, back_ff;
   logic [CHAN_W-1:0]     a_ff, acc_ff, alpha_cur;
   logic [FADE_W-1:0]     inv_alpha;
   logic [ADDR_W-1:0]     addr_ff;
   logic [PIX_W-1:0]      pix_ff;
   logic [AW-1:0]         addr_sum;
   logic [CHAN_W:0]       chan_sum;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_we_ff, rsp_last_ff;
   logic [ADDR_W-1:0]     rsp_addr_ff;
   logic [PIX_W-1:0]      rsp_pix_ff;

   assign start   = req_valid && req_ready;
   assign last_op = flags_ff.blend ? OP_B_BACK : OP_ADDR;

   // alpha bypass straight from the product register on the first channel op
   assign alpha_cur = (vld_ff && tag_ff == OP_ALPHA) ? mul_p[15:8] : a_ff;
   assign inv_alpha = FADE_W'(9'd256 - {1'b0, alpha_cur});

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (op_ff)
         OP_ADDR: begin
            mul_a = MUL_W'(y_ff);
            mul_b = MUL_W'(scr_w);
         end
         OP_ALPHA: begin
            mul_a = MUL_W'(src_ff[31:24]);
            mul_b = MUL_W'(fade);
         end
         OP_R_SRC: begin
            mul_a = MUL_W'(src_ff[23:16]);
            mul_b = MUL_W'(alpha_cur);
         end
         OP_R_BACK: begin
            mul_a = MUL_W'(back_ff[23:16]);
            mul_b = MUL_W'(inv_alpha);
         end
         OP_G_SRC: begin
            mul_a = MUL_W'(src_ff[15:8]);
            mul_b = MUL_W'(alpha_cur);
         end
         OP_G_BACK: begin
            mul_a = MUL_W'(back_ff[15:8]);
            mul_b = MUL_W'(inv_alpha);
         end
         OP_B_SRC: begin
            mul_a = MUL_W'(src_ff[7:0]);
            mul_b = MUL_W'(alpha_cur);
         end
         OP_B_BACK: begin
            mul_a = MUL_W'(back_ff[7:0]);
            mul_b = MUL_W'(inv_alpha);
         end
         default: ;
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      req_ready = 1'b0;
      issue     = 1'b0;
      load      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            op_in     = OP_ADDR;
            if (req_valid) begin
               state_in = flags.write_en ? ST_ISSUE : ST_DONE;
            end
         end
         ST_ISSUE: begin
            issue = 1'b1;
            if (op_ff == last_op) begin
               state_in = ST_DRAIN;
            end else begin
               op_in = op_type'(op_ff + 3'd1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign vld_in       = issue;
   assign rsp_valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_ADDR;
         vld_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign addr_sum = AW'(mul_p) + AW'(x_ff);
   assign chan_sum = {1'b0, acc_ff} + mul_p[16:8];

   // job registers and product consume
   always_ff @(posedge clock) begin
      tag_ff <= op_ff;
      if (start) begin
         flags_ff <= flags;
         x_ff     <= x;
         y_ff     <= y;
         src_ff   <= src;
         back_ff  <= back;
         addr_ff  <= '0;
         pix_ff   <= (flags.write_en && !flags.blend) ? src : '0;
      end
      if (vld_ff) begin
         case (tag_ff)
            OP_ADDR:   addr_ff <= addr_sum[ADDR_W-1:0];
            OP_ALPHA:  a_ff <= mul_p[15:8];
            OP_R_SRC,
            OP_G_SRC,
            OP_B_SRC:  acc_ff <= mul_p[15:8];
            OP_R_BACK: pix_ff[23:16] <= chan_sum[CHAN_W-1:0];
            OP_G_BACK: pix_ff[15:8] <= chan_sum[CHAN_W-1:0];
            OP_B_BACK: pix_ff[7:0] <= chan_sum[CHAN_W-1:0];
            default: ;
         endcase
      end
      if (load) begin
         rsp_we_ff   <= flags_ff.write_en;
         rsp_addr_ff <= addr_ff;
         rsp_pix_ff  <= pix_ff;
         rsp_last_ff <= flags_ff.last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_we    = rsp_we_ff;
   assign rsp_addr  = rsp_addr_ff;
   assign rsp_pix   = rsp_pix_ff;
   assign rsp_last  = rsp_last_ff;

endmodule

/* hw/rtl/clipped_alpha_blit_core.sv */
`timescale 1ns / 1ps
// Sequence: after the request beat the sequencer issues its multiplier products, drains the last one
//           and loads the result beat; a pixel that is not written goes straight to the result beat.
// One pixel in flight: no new request is taken until the result beat is loaded. One shared
// multiplier takes address, alpha and six channel products in turn (address only in solid mode).
// Reset (synchronous, active high): registers to their defaults, counters to 0, no beat pending.

module clipped_alpha_blit_core #(
   parameter int MAX_DIM = 2048
) (
   input  logic                          clock,
   input  logic                          reset,
   // request: [31:0] src_pixel, [63:32] back_pixel
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [63:0]                   req_tdata,
   // response: [0] write_enable, [22:1] dest_address, [54:23] out_pixel, [55] zero
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [55:0]                   rsp_tdata,
   output logic                          rsp_tlast,   // last_pixel
   input  logic                          csr_we,
   input  logic [cab_pkg::CSR_IDX_W-1:0] csr_addr,
   input  logic [cab_pkg::CSR_W-1:0]     csr_wdata
);

   import cab_pkg::*;

   localparam int CNT_W = $clog2(MAX_DIM);
   localparam int DIM_W = $clog2(MAX_DIM + 1);
   localparam int MUL_W = (DIM_W > FADE_W) ? DIM_W : FADE_W;
   localparam logic [DIM_CALC_W-1:0] DIM_LIM = DIM_CALC_W'(MAX_DIM);

   // configuration registers
   logic signed [POS_W-1:0] pos_x_ff, pos_y_ff;
   logic [DIM_REG_W-1:0]    img_w_ff, img_h_ff, scr_w_ff, scr_h_ff;
   logic [FADE_W-1:0]       fade_ff;
   logic                    alpha_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff      <= '0;
         pos_y_ff      <= '0;
         img_w_ff      <= DIM_REG_W'(1);
         img_h_ff      <= DIM_REG_W'(1);
         scr_w_ff      <= DIM_REG_W'(1);
         scr_h_ff      <= DIM_REG_W'(1);
         fade_ff       <= FADE_W'(256);
         alpha_mode_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_addr))
            CSR_POS_X:         pos_x_ff      <= csr_wdata[POS_W-1:0];
            CSR_POS_Y:         pos_y_ff      <= csr_wdata[POS_W-1:0];
            CSR_IMAGE_WIDTH:   img_w_ff      <= csr_wdata[DIM_REG_W-1:0];
            CSR_IMAGE_HEIGHT:  img_h_ff      <= csr_wdata[DIM_REG_W-1:0];
            CSR_SCREEN_WIDTH:  scr_w_ff      <= csr_wdata[DIM_REG_W-1:0];
            CSR_SCREEN_HEIGHT: scr_h_ff      <= csr_wdata[DIM_REG_W-1:0];
            CSR_FADE_Q8:       fade_ff       <= csr_wdata[FADE_W-1:0];
            CSR_ALPHA_MODE:    alpha_mode_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // sizes clamped to 1..MAX_DIM; fade above 1.0 saturates (bit 8 set means >= 256)
   logic [DIM_W-1:0]  img_w, img_h, scr_w, scr_h;
   logic [FADE_W-1:0] fade_sat;
   logic              enable;

   assign img_w    = DIM_W'(clamp_dim(img_w_ff, DIM_LIM));
   assign img_h    = DIM_W'(clamp_dim(img_h_ff, DIM_LIM));
   assign scr_w    = DIM_W'(clamp_dim(scr_w_ff, DIM_LIM));
   assign scr_h    = DIM_W'(clamp_dim(scr_h_ff, DIM_LIM));
   assign fade_sat = fade_ff[FADE_W-1] ? FADE_W'(256) : fade_ff;
   // zero fade in alpha mode suppresses all writes
   assign enable   = !(alpha_mode_ff && fade_sat == '0);

   logic                req_accept;
   logic [CNT_W-1:0]    pix_x, pix_y;
   job_flags_type       flags;
   logic [MUL_W-1:0]    mul_a, mul_b;
   logic [2*MUL_W-1:0]  mul_p;
   logic                rsp_we;
   logic [ADDR_W-1:0]   rsp_addr;
   logic [PIX_W-1:0]    rsp_pix;

   assign req_accept = req_tvalid && req_tready;

   // raster counters and clipping; advance once per request beat
   cab_pos #(.MAX_DIM(MAX_DIM)) u_pos (
      .clock      (clock),
      .reset      (reset),
      .step       (req_accept),
      .pos_x      (pos_x_ff),
      .pos_y      (pos_y_ff),
      .img_w      (img_w),
      .img_h      (img_h),
      .scr_w      (scr_w),
      .scr_h      (scr_h),
      .enable     (enable),
      .blend_mode (alpha_mode_ff),
      .x          (pix_x),
      .y          (pix_y),
      .flags      (flags)
   );

   // the one shared multiplier, product registered
   cab_mul #(.W(MUL_W)) u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .prod_ff (mul_p)
   );

   // sequencer: schedules products, accumulates channels, holds the result beat
   cab_seq #(.MAX_DIM(MAX_DIM)) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .src       (req_tdata[31:0]),
      .back      (req_tdata[63:32]),
      .flags     (flags),
      .x         (pix_x),
      .y         (pix_y),
      .scr_w     (scr_w),
      .fade      (fade_sat),
      .mul_a     (mul_a),
      .mul_b     (mul_b),
      .mul_p     (mul_p),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_we    (rsp_we),
      .rsp_addr  (rsp_addr),
      .rsp_pix   (rsp_pix),
      .rsp_last  (rsp_tlast)
   );

   assign rsp_tdata = {1'b0, rsp_pix, rsp_addr, rsp_we};

   // one pixel in flight: ready drops right after a request beat
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while a pixel is in flight");

   // unwritten pixels carry zero address and data
   a_unwritten_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[55:1] == '0)
      else $error("unwritten pixel with nonzero address or data");

   // a new result beat only appears while no request can be taken
   a_rsp_rise_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result beat raised from idle");

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;
   import cab_pkg::*;

   localparam int MAX_DIM        = 2048;
   localparam int RANDOM_PIXELS  = 1300;
   localparam int SETTLE_CYCLES  = 12;    // longer than the worst latency (alpha mode)
   localparam int HOLD_OFF       = 300;   // one long sink stall, fills the core
   localparam int WATCHDOG_LIMIT = 2000;  // cycles with no beat on either side

   // one framebuffer write as the core reports it
   typedef struct packed {
      logic        we;
      logic [21:0] addr;
      logic [31:0] pix;
      logic        last;
   } pixel_write_type;

   typedef enum {ROW_REG, ROW_PIX} row_kind_type;

   // directed script: register writes and pixels, optionally with a typed-in result
   typedef struct {
      row_kind_type    kind;
      csr_idx_type     idx;
      int              value;
      logic [31:0]     src;
      logic [31:0]     back;
      bit              typed;
      pixel_write_type want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [63:0]          req_tdata  = '0;  // [31:0] src_pixel, [63:32] back_pixel
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [55:0]          rsp_tdata;        // [0] we, [22:1] addr, [54:23] pixel, [55] zero
   logic                 rsp_tlast;        // last_pixel
   logic                 csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0] csr_addr   = '0;
   logic [CSR_W-1:0]     csr_wdata  = '0;

   // shadow of the register file, reset values
   logic signed [12:0] cfg_pos_x    = '0;
   logic signed [12:0] cfg_pos_y    = '0;
   logic [11:0]        cfg_image_w  = 12'd1;
   logic [11:0]        cfg_image_h  = 12'd1;
   logic [11:0]        cfg_screen_w = 12'd1;
   logic [11:0]        cfg_screen_h = 12'd1;
   logic [8:0]         cfg_fade     = 9'd256;
   logic               cfg_alpha    = 1'b0;

   // raster position of the next source pixel
   logic [10:0] col_cnt = '0;
   logic [10:0] row_cnt = '0;

   pixel_write_type pending_writes[$];
   stim_row_type    script[$];

   int mismatches      = 0;
   int pixels_sent     = 0;
   int writes_seen     = 0;
   int skipped_seen    = 0;
   int image_ends      = 0;
   int phases          = 0;
   int quiet_cycles    = 0;
   int max_gap         = 6;
   int max_stall       = 6;
   int hold_off_cycles = 0;

   clipped_alpha_blit_core #(
      .MAX_DIM(MAX_DIM)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // size registers: zero reads as one, oversize reads as MAX_DIM
   function automatic int dim_read(input logic [11:0] v);
      if (v == 12'd0)
         return 1;
      if (v > MAX_DIM)
         return MAX_DIM;
      return int'(v);
   endfunction

   // What the core must write for this pixel; steps the raster counters.
   function automatic pixel_write_type blit_write_for(input logic [31:0] src,
                                                      input logic [31:0] back);
      pixel_write_type w;
      int              iw, ih, sw, sh, fade, xi, yi, a, s, b, ch;
      logic [31:0]     lin;
      bit              on_screen, end_row, end_img;
      iw   = dim_read(cfg_image_w);
      ih   = dim_read(cfg_image_h);
      sw   = dim_read(cfg_screen_w);
      sh   = dim_read(cfg_screen_h);
      fade = (cfg_fade > 9'd256) ? 256 : int'(cfg_fade);
      xi   = int'(cfg_pos_x) + int'(col_cnt);
      yi   = int'(cfg_pos_y) + int'(row_cnt);
      on_screen = xi >= 0 && yi >= 0 && xi < sw && yi < sh;
      end_row   = int'(col_cnt) >= iw - 1;
      end_img   = end_row && int'(row_cnt) >= ih - 1;
      w      = '0;
      w.we   = on_screen && !(cfg_alpha && fade == 0);
      w.last = end_img;
      if (w.we) begin
         lin    = yi * sw + xi;
         w.addr = lin[21:0];
         if (cfg_alpha) begin
            a = (int'(src[31:24]) * fade) >> 8;
            // alpha byte of the written pixel stays 0
            for (int c = 0; c < 3; c++) begin
               s  = int'(src[8*c +: 8]);
               b  = int'(back[8*c +: 8]);
               ch = ((s * a) >> 8) + ((b * (256 - a)) >> 8);
               w.pix[8*c +: 8] = ch[7:0];
            end
         end else begin
            w.pix = src;
         end
      end
      if (end_row) begin
         col_cnt = '0;
         row_cnt = end_img ? 11'd0 : row_cnt + 11'd1;
      end else begin
         col_cnt = col_cnt + 11'd1;
      end
      return w;
   endfunction

   function automatic void reg_row(input csr_idx_type idx, input int value);
      stim_row_type r;
      r.kind  = ROW_REG;
      r.idx   = idx;
      r.value = value;
      r.src   = '0;
      r.back  = '0;
      r.typed = 1'b0;
      r.want  = '0;
      script.push_back(r);
   endfunction

   function automatic void pix_row(input logic [31:0] src, input logic [31:0] back,
                                   input bit typed = 1'b0, input bit we = 1'b0,
                                   input int addr = 0, input logic [31:0] pix = '0,
                                   input bit last = 1'b0);
      stim_row_type r;
      r.kind      = ROW_PIX;
      r.idx       = CSR_POS_X;
      r.value     = 0;
      r.src       = src;
      r.back      = back;
      r.typed     = typed;
      r.want.we   = we;
      r.want.addr = addr[21:0];
      r.want.pix  = pix;
      r.want.last = last;
      script.push_back(r);
   endfunction

   // Offer one pixel after a random gap; hold tvalid until the core takes it.
   // Entered and left at a rising edge.
   task automatic send_pixel(input logic [31:0] src, input logic [31:0] back,
                             input bit typed, input pixel_write_type want);
      int              gap;
      pixel_write_type pred;
      gap = $urandom_range(0, max_gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {back, src};
      do @(posedge clock); while (req_tready !== 1'b1);
      // accepted at this edge: step the predictor
      pred = blit_write_for(src, back);
      pending_writes.push_back(typed ? want : pred);
      pixels_sent++;
   endtask

   // Register write: only once every queued write has come back and the core
   // has had time to settle.
   task automatic write_reg(input csr_idx_type idx, input int value);
      logic [12:0] v;
      v = value[12:0];
      req_tvalid <= 1'b0;
      while (pending_writes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= v;
      @(posedge clock);
      case (idx)
         CSR_POS_X:         cfg_pos_x    = v;
         CSR_POS_Y:         cfg_pos_y    = v;
         CSR_IMAGE_WIDTH:   cfg_image_w  = v[11:0];
         CSR_IMAGE_HEIGHT:  cfg_image_h  = v[11:0];
         CSR_SCREEN_WIDTH:  cfg_screen_w = v[11:0];
         CSR_SCREEN_HEIGHT: cfg_screen_h = v[11:0];
         CSR_FADE_Q8:       cfg_fade     = v[8:0];
         CSR_ALPHA_MODE:    cfg_alpha    = v[0];
         default: ;
      endcase
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // mostly small offsets around the screen corner, now and then the extremes
   function automatic int pick_offset();
      if ($urandom_range(0, 7) == 0)
         return ($urandom_range(0, 1) == 1) ? -4096 : 4095;
      return int'($urandom_range(0, 30)) - 10;
   endfunction

   // small sizes mostly; zero and oversize read as 1 and MAX_DIM
   function automatic int pick_size(input int typical_max);
      case ($urandom_range(0, 11))
         0:       return 0;
         1:       return MAX_DIM;
         2:       return 4095;
         default: return int'($urandom_range(1, typical_max));
      endcase
   endfunction

   // Sink: random stall before each beat, plus the one long hold-off.
   initial begin : sink
      int n;
      forever begin
         if (hold_off_cycles > 0) begin
            n = hold_off_cycles;
            hold_off_cycles = 0;
         end else begin
            n = $urandom_range(0, max_stall);
         end
         if (n > 0) begin
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
      end
   end

   // Response checker: every beat against the oldest queued write.
   always @(posedge clock) begin : check_writes
      pixel_write_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         if (pending_writes.size() == 0) begin
            $error("write beat with nothing pending: tdata=%h last=%b", rsp_tdata, rsp_tlast);
            mismatches++;
         end else begin
            want = pending_writes.pop_front();
            if (rsp_tdata[0] !== want.we) begin
               $error("write_enable: expected %0d, got %0d", want.we, rsp_tdata[0]);
               mismatches++;
            end
            if (rsp_tdata[22:1] !== want.addr) begin
               $error("dest_address: expected %0d, got %0d", want.addr, rsp_tdata[22:1]);
               mismatches++;
            end
            if (rsp_tdata[54:23] !== want.pix) begin
               $error("out_pixel: expected %h, got %h", want.pix, rsp_tdata[54:23]);
               mismatches++;
            end
            if (rsp_tdata[55] !== 1'b0) begin
               $error("pad bit: expected 0, got %b", rsp_tdata[55]);
               mismatches++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last_pixel: expected %0d, got %0d", want.last, rsp_tlast);
               mismatches++;
            end
            if (want.we)
               writes_seen++;
            else
               skipped_seen++;
            if (want.last)
               image_ends++;
         end
      end
   end

   // Watchdog: too long without a beat on either side means the core hung.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready === 1'b1) || (rsp_tvalid === 1'b1 && rsp_tready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no beat for %0d cycles, %0d writes pending",
                  quiet_cycles, pending_writes.size());
         $display("clipped_alpha_blit_core: mismatch");
         $finish;
      end
   end

   initial begin : stimulus
      int          n;
      int          random_pixels;
      logic [31:0] src;
      logic [31:0] back;

      random_pixels = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed ---
      // reset config is a 1x1 image on a 1x1 screen, solid copy
      pix_row(32'hFFFF_FFFF, 32'h0000_0000, 1, 1, 0, 32'hFFFF_FFFF, 1);
      pix_row(32'h0000_0000, 32'hFFFF_FFFF, 1, 1, 0, 32'h0000_0000, 1);
      // zero sizes read as 1
      reg_row(CSR_SCREEN_HEIGHT, 0);
      reg_row(CSR_IMAGE_WIDTH, 0);
      pix_row(32'hA5A5_A5A5, 32'h5A5A_5A5A, 1, 1, 0, 32'hA5A5_A5A5, 1);
      // 3x2 image straddling the right edge of a 2048x1 screen (4095 saturates)
      reg_row(CSR_SCREEN_WIDTH, 4095);
      reg_row(CSR_IMAGE_WIDTH, 3);
      reg_row(CSR_IMAGE_HEIGHT, 2);
      reg_row(CSR_POS_X, 2046);
      pix_row(32'h1234_5678, 32'hCAFE_F00D, 1, 1, 2046, 32'h1234_5678, 0);
      pix_row(32'h8765_4321, 32'h0BAD_BEEF);
      pix_row(32'hDEAD_BEEF, 32'h1111_1111, 1, 0, 0, 32'h0, 0);  // off right edge
      pix_row(32'h0102_0304, 32'h2222_2222, 1, 0, 0, 32'h0, 0);  // off bottom
      pix_row(32'h0506_0708, 32'h3333_3333);
      pix_row(32'h090A_0B0C, 32'h4444_4444, 1, 0, 0, 32'h0, 1);  // image end, clipped
      // offsets at both signed extremes: nothing lands on screen
      reg_row(CSR_POS_X, -4096);
      reg_row(CSR_POS_Y, 4095);
      pix_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 0, 0, 32'h0, 0);
      // alpha mode with zero fade writes nothing
      reg_row(CSR_POS_X, 0);
      reg_row(CSR_POS_Y, 0);
      reg_row(CSR_SCREEN_HEIGHT, 4095);
      reg_row(CSR_ALPHA_MODE, 1);
      reg_row(CSR_FADE_Q8, 0);
      pix_row(32'hFFFF_FFFF, 32'h0000_0000, 1, 0, 0, 32'h0, 0);
      // fade above 1.0 saturates
      reg_row(CSR_FADE_Q8, 511);
      pix_row(32'hFF00_00FF, 32'h00FF_FF00);
      // transparent source: background comes through, alpha byte cleared
      pix_row(32'h0011_2233, 32'hAA44_5566, 1, 1, 2048, 32'h0044_5566, 0);
      pix_row(32'hFFFF_00FF, 32'h0000_0000);
      pix_row(32'h80FF_8040, 32'h4040_4040);
      // tiny fade rounds effective alpha to zero
      reg_row(CSR_FADE_Q8, 1);
      pix_row(32'hFFFF_FFFF, 32'h0012_3456, 1, 1, 0, 32'h0012_3456, 0);
      // shrink the image under the running counters
      reg_row(CSR_FADE_Q8, 256);
      reg_row(CSR_ALPHA_MODE, 0);
      reg_row(CSR_IMAGE_WIDTH, 8);
      reg_row(CSR_IMAGE_HEIGHT, 8);
      pix_row(32'h1357_9BDF, 32'h0);
      pix_row(32'h2468_ACE0, 32'h0);
      pix_row(32'hF0E1_D2C3, 32'h0);
      reg_row(CSR_IMAGE_WIDTH, 2);
      reg_row(CSR_IMAGE_HEIGHT, 1);
      pix_row(32'h0F0F_0F0F, 32'h0, 1, 1, 4, 32'h0F0F_0F0F, 1);
      reg_row(CSR_IMAGE_WIDTH, 1);
      reg_row(CSR_IMAGE_HEIGHT, 4);
      pix_row(32'h7777_7777, 32'h0);
      pix_row(32'h8888_8888, 32'h0);
      reg_row(CSR_IMAGE_HEIGHT, 2);
      pix_row(32'h9999_9999, 32'h0, 1, 1, 4096, 32'h9999_9999, 1);

      foreach (script[i]) begin
         if (script[i].kind == ROW_REG)
            write_reg(script[i].idx, script[i].value);
         else
            send_pixel(script[i].src, script[i].back, script[i].typed, script[i].want);
      end

      // --- random phases: new register set, then a burst of pixels ---
      while (random_pixels < RANDOM_PIXELS) begin
         phases++;
         write_reg(CSR_POS_X, pick_offset());
         write_reg(CSR_POS_Y, pick_offset());
         write_reg(CSR_IMAGE_WIDTH, pick_size(8));
         write_reg(CSR_IMAGE_HEIGHT, pick_size(6));
         write_reg(CSR_SCREEN_WIDTH, pick_size(16));
         write_reg(CSR_SCREEN_HEIGHT, pick_size(16));
         case ($urandom_range(0, 5))
            0:       write_reg(CSR_FADE_Q8, 0);
            1:       write_reg(CSR_FADE_Q8, 256);
            2:       write_reg(CSR_FADE_Q8, 511);
            3:       write_reg(CSR_FADE_Q8, 255);
            default: write_reg(CSR_FADE_Q8, int'($urandom_range(0, 511)));
         endcase
         write_reg(CSR_ALPHA_MODE, int'($urandom_range(0, 1)));

         // some phases run back to back on one side or both
         max_gap   = ($urandom_range(0, 3) == 0) ? 0 : 6;
         max_stall = ($urandom_range(0, 3) == 0) ? 0 : 6;
         if (phases == 3) begin
            // sink goes quiet while the source keeps pushing
            max_gap         = 0;
            hold_off_cycles = HOLD_OFF;
         end

         n = $urandom_range(10, 60);
         repeat (n) begin
            src  = $urandom;
            back = $urandom;
            case ($urandom_range(0, 3))
               0:       src[31:24] = 8'h00;
               1:       src[31:24] = 8'hFF;
               default: ;
            endcase
            send_pixel(src, back, 1'b0, '0);
         end
         random_pixels += n;
      end

      req_tvalid <= 1'b0;
      while (pending_writes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("ran %0d pixels (%0d register phases): %0d written, %0d clipped or faded out",
               pixels_sent, phases, writes_seen, skipped_seen);
      $display("%0d image ends seen, solid and blended modes, offsets and sizes at extremes",
               image_ends);
      if (mismatches == 0)
         $display("clipped_alpha_blit_core: match");
      else
         $display("clipped_alpha_blit_core: mismatch");
      $finish;
   end

endmodule
